>>> src/qrs_pkg.sv
// Shared constants, status codes and the front-to-back job record for the
// quadratic root solver. No dependencies.
`default_nettype none

package qrs_pkg;

   localparam int WORD_BITS = 32;
   localparam int FRAC_BITS = 16;

   // discriminant: b*b + 4*|a*c| < 2^(2W+1)
   localparam int DISC_BITS = 2 * WORD_BITS + 1;

   // square root: one result bit per stage
   localparam int SQ_STAGES    = WORD_BITS + 1;
   localparam int SQ_ROOT_BITS = WORD_BITS + 1;
   localparam int SQ_REM_BITS  = WORD_BITS + 4;
   localparam int SQ_PAD_BITS  = 2 * SQ_STAGES;

   // numerator -b +/- sqrt(D)
   localparam int NUM_MAG_BITS = WORD_BITS + 2;
   localparam int NUM_SUM_BITS = WORD_BITS + 3;

   // division by 2a with rounding offset
   localparam int DIVIDEND_BITS = WORD_BITS + FRAC_BITS + 3;
   localparam int DIV_REM_BITS  = WORD_BITS + 2;
   localparam int DEN_BITS      = WORD_BITS + 1;

   localparam int FIFO_DEPTH    = 4;
   localparam int FIFO_PTR_BITS = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS = $clog2(FIFO_DEPTH + 1);

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_A_ZERO = 2'd1,
      ST_D_NEG  = 2'd2,
      ST_SAT    = 2'd3
   } qrs_status_type;

   typedef struct packed {
      qrs_status_type         cls;
      logic [DISC_BITS-1:0]   disc;
      logic                   b_neg;
      logic [WORD_BITS-1:0]   b_mag;
      logic                   a_neg;
      logic [WORD_BITS-1:0]   a_mag;
   } qrs_job_type;

endpackage

`default_nettype wire

>>> src/qrs_front.sv
// Front end: takes coefficient transactions, forms magnitudes, products and
// the discriminant, and classifies each equation. Depends on qrs_pkg.
`default_nettype none

module qrs_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_a,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_b,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_c,
   input  wire logic                                 fifo_full,
   output logic                                      push,
   output qrs_pkg::qrs_job_type                      push_job
);

   localparam int W  = qrs_pkg::WORD_BITS;
   localparam int DW = qrs_pkg::DISC_BITS;

   logic         fen;
   logic         f1_v_ff, f1_v_in;
   logic         f1_a_neg_ff, f1_b_neg_ff, f1_c_neg_ff;
   logic [W-1:0] f1_a_mag_ff, f1_b_mag_ff, f1_c_mag_ff;
   logic [W-1:0] f1_a_mag_in, f1_b_mag_in, f1_c_mag_in;

   logic           f2_v_ff;
   logic           f2_a_neg_ff, f2_b_neg_ff, f2_c_neg_ff, f2_c_zero_ff;
   logic [W-1:0]   f2_a_mag_ff, f2_b_mag_ff;
   logic [2*W-1:0] f2_bb_ff, f2_ac_ff, f2_bb_in, f2_ac_in;

   logic [DW-1:0] fac, sum;
   logic [DW:0]   diff;
   logic          sub_case;

   assign fen       = !(f2_v_ff && fifo_full);
   assign req_stall = !fen;
   assign f1_v_in   = req_valid;

   always_comb begin
      f1_a_mag_in = req_coef_a[W-1] ? -req_coef_a : req_coef_a;
      f1_b_mag_in = req_coef_b[W-1] ? -req_coef_b : req_coef_b;
      f1_c_mag_in = req_coef_c[W-1] ? -req_coef_c : req_coef_c;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_v_ff <= 1'b0;
      end else if (fen) begin
         f1_v_ff <= f1_v_in;
      end
      if (fen) begin
         f1_a_neg_ff <= req_coef_a[W-1];
         f1_b_neg_ff <= req_coef_b[W-1];
         f1_c_neg_ff <= req_coef_c[W-1];
         f1_a_mag_ff <= f1_a_mag_in;
         f1_b_mag_ff <= f1_b_mag_in;
         f1_c_mag_ff <= f1_c_mag_in;
      end
   end

   always_comb begin
      f2_bb_in = f1_b_mag_ff * f1_b_mag_ff;
      f2_ac_in = f1_a_mag_ff * f1_c_mag_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f2_v_ff <= 1'b0;
      end else if (fen) begin
         f2_v_ff <= f1_v_ff;
      end
      if (fen) begin
         f2_a_neg_ff  <= f1_a_neg_ff;
         f2_b_neg_ff  <= f1_b_neg_ff;
         f2_c_neg_ff  <= f1_c_neg_ff;
         f2_c_zero_ff <= (f1_c_mag_ff == '0);
         f2_a_mag_ff  <= f1_a_mag_ff;
         f2_b_mag_ff  <= f1_b_mag_ff;
         f2_bb_ff     <= f2_bb_in;
         f2_ac_ff     <= f2_ac_in;
      end
   end

   always_comb begin
      fac      = DW'({f2_ac_ff, 2'b00});
      sum      = DW'(f2_bb_ff) + fac;
      diff     = (DW + 1)'(f2_bb_ff) - (DW + 1)'(fac);
      sub_case = !f2_c_zero_ff && (f2_a_neg_ff == f2_c_neg_ff);

      push_job.disc  = sub_case ? diff[DW-1:0] : sum;
      push_job.b_neg = f2_b_neg_ff;
      push_job.b_mag = f2_b_mag_ff;
      push_job.a_neg = f2_a_neg_ff;
      push_job.a_mag = f2_a_mag_ff;
      if (f2_a_mag_ff == '0) begin
         push_job.cls = qrs_pkg::ST_A_ZERO;
      end else if (sub_case && diff[DW]) begin
         push_job.cls = qrs_pkg::ST_D_NEG;
      end else begin
         push_job.cls = qrs_pkg::ST_OK;
      end
   end

   assign push = f2_v_ff && !fifo_full;

endmodule

`default_nettype wire

>>> src/qrs_fifo.sv
// Short job queue between the front end and the back end.
// Depends on qrs_pkg.
`default_nettype none

module qrs_fifo (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire qrs_pkg::qrs_job_type push_job,
   input  wire logic                 pop,
   output qrs_pkg::qrs_job_type      head_job,
   output logic                      empty,
   output logic                      full
);

   localparam int PW = qrs_pkg::FIFO_PTR_BITS;
   localparam int CW = qrs_pkg::FIFO_CNT_BITS;

   qrs_pkg::qrs_job_type mem_ff [qrs_pkg::FIFO_DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty    = (count_ff == '0);
   assign full     = (count_ff == CW'(qrs_pkg::FIFO_DEPTH));
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop)
      else $error("queue read while empty");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("queue count lost a transaction");

endmodule

`default_nettype wire

>>> src/qrs_back.sv
// Back end: pipelined square root, numerators, two pipelined dividers by 2a,
// rounding, saturation and the result register. Depends on qrs_pkg.
`default_nettype none

module qrs_back (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            fifo_empty,
   input  wire qrs_pkg::qrs_job_type            head_job,
   output logic                                 pop,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic signed [qrs_pkg::WORD_BITS-1:0] rsp_root_plus,
   output logic signed [qrs_pkg::WORD_BITS-1:0] rsp_root_minus,
   output logic [1:0]                           rsp_status
);

   localparam int W    = qrs_pkg::WORD_BITS;
   localparam int F    = qrs_pkg::FRAC_BITS;
   localparam int SQ   = qrs_pkg::SQ_STAGES;
   localparam int RW   = qrs_pkg::SQ_ROOT_BITS;
   localparam int REMW = qrs_pkg::SQ_REM_BITS;
   localparam int DPW  = qrs_pkg::SQ_PAD_BITS;
   localparam int NMW  = qrs_pkg::NUM_MAG_BITS;
   localparam int NSW  = qrs_pkg::NUM_SUM_BITS;
   localparam int NUMW = qrs_pkg::DIVIDEND_BITS;
   localparam int DVRW = qrs_pkg::DIV_REM_BITS;
   localparam int DENW = qrs_pkg::DEN_BITS;

   function automatic logic [W:0] clamp_root(input logic sign_neg, input logic ovf,
                                             input logic [W-1:0] q);
      logic       neg;
      logic [W:0] res;
      neg = sign_neg && (ovf || (q != '0));
      if (!neg && (ovf || q[W-1])) begin
         res = {1'b1, 1'b0, {(W-1){1'b1}}};
      end else if (neg && (ovf || (q[W-1] && (q[W-2:0] != '0)))) begin
         res = {1'b1, 1'b1, {(W-1){1'b0}}};
      end else if (neg) begin
         res = {1'b0, -q};
      end else begin
         res = {1'b0, q};
      end
      return res;
   endfunction

   logic ben;

   // square root stages
   logic                 sq_v_ff    [SQ];
   logic [REMW-1:0]      sq_rem_ff  [SQ];
   logic [RW-1:0]        sq_root_ff [SQ];
   logic [DPW-1:0]       sq_d_ff    [SQ];
   qrs_pkg::qrs_job_type sq_job_ff  [SQ];

   // numerator stage
   logic                   n_v_ff;
   qrs_pkg::qrs_status_type n_cls_ff;
   logic                   n_aneg_ff, n_pneg_ff, n_mneg_ff;
   logic [W-1:0]           n_amag_ff;
   logic [NMW-1:0]         n_pmag_ff, n_mmag_ff, n_pmag_in, n_mmag_in;
   logic signed [NSW-1:0]  nb, sv, sum_p, sum_m;

   // division setup stage
   logic                    p_v_ff;
   qrs_pkg::qrs_status_type p_cls_ff;
   logic                    p_negp_ff, p_negm_ff, p_ovfp_ff, p_ovfm_ff;
   logic [DENW-1:0]         p_den_ff, p_den_in;
   logic [DVRW-1:0]         p_remp_ff, p_remm_ff;
   logic [W-1:0]            p_lop_ff, p_lom_ff;
   logic [NUMW-1:0]         nump, numm, hip, him;

   // division stages
   logic                    dv_v_ff    [W];
   qrs_pkg::qrs_status_type dv_cls_ff  [W];
   logic                    dv_negp_ff [W];
   logic                    dv_negm_ff [W];
   logic                    dv_ovfp_ff [W];
   logic                    dv_ovfm_ff [W];
   logic [DENW-1:0]         dv_den_ff  [W];
   logic [DVRW-1:0]         dv_remp_ff [W];
   logic [DVRW-1:0]         dv_remm_ff [W];
   logic [W-1:0]            dv_lop_ff  [W];
   logic [W-1:0]            dv_lom_ff  [W];
   logic [W-1:0]            dv_qp_ff   [W];
   logic [W-1:0]            dv_qm_ff   [W];

   // result register
   logic                    rsp_valid_ff;
   logic [W-1:0]            rsp_plus_ff, rsp_minus_ff;
   qrs_pkg::qrs_status_type rsp_status_ff, rsp_status_in;
   logic [W:0]              cl_p, cl_m;

   assign ben = !(rsp_valid_ff && rsp_stall);
   assign pop = ben && !fifo_empty;

   for (genvar k = 0; k < SQ; k++) begin : g_sq
      logic                 v_i;
      logic [REMW-1:0]      rem_i, sh, trial, rem_in;
      logic [RW-1:0]        root_i, root_in;
      logic [DPW-1:0]       d_i;
      qrs_pkg::qrs_job_type job_i;
      logic                 ge;

      if (k == 0) begin : g_head
         assign v_i    = !fifo_empty;
         assign rem_i  = '0;
         assign root_i = '0;
         assign d_i    = DPW'(head_job.disc);
         assign job_i  = head_job;
      end else begin : g_link
         assign v_i    = sq_v_ff[k-1];
         assign rem_i  = sq_rem_ff[k-1];
         assign root_i = sq_root_ff[k-1];
         assign d_i    = sq_d_ff[k-1];
         assign job_i  = sq_job_ff[k-1];
      end

      always_comb begin
         sh      = {rem_i[REMW-3:0], d_i[DPW-1 -: 2]};
         trial   = REMW'({root_i, 2'b01});
         ge      = (sh >= trial);
         rem_in  = ge ? sh - trial : sh;
         root_in = {root_i[RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_v_ff[k] <= 1'b0;
         end else if (ben) begin
            sq_v_ff[k] <= v_i;
         end
         if (ben) begin
            sq_rem_ff[k]  <= rem_in;
            sq_root_ff[k] <= root_in;
            sq_d_ff[k]    <= {d_i[DPW-3:0], 2'b00};
            sq_job_ff[k]  <= job_i;
         end
      end
   end

   always_comb begin
      nb        = sq_job_ff[SQ-1].b_neg ? $signed(NSW'(sq_job_ff[SQ-1].b_mag))
                                        : -$signed(NSW'(sq_job_ff[SQ-1].b_mag));
      sv        = $signed(NSW'(sq_root_ff[SQ-1]));
      sum_p     = nb + sv;
      sum_m     = nb - sv;
      n_pmag_in = NMW'(sum_p[NSW-1] ? -sum_p : sum_p);
      n_mmag_in = NMW'(sum_m[NSW-1] ? -sum_m : sum_m);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_v_ff <= 1'b0;
      end else if (ben) begin
         n_v_ff <= sq_v_ff[SQ-1];
      end
      if (ben) begin
         n_cls_ff  <= sq_job_ff[SQ-1].cls;
         n_aneg_ff <= sq_job_ff[SQ-1].a_neg;
         n_amag_ff <= sq_job_ff[SQ-1].a_mag;
         n_pneg_ff <= sum_p[NSW-1];
         n_mneg_ff <= sum_m[NSW-1];
         n_pmag_ff <= n_pmag_in;
         n_mmag_ff <= n_mmag_in;
      end
   end

   always_comb begin
      p_den_in = {n_amag_ff, 1'b0};
      nump     = (NUMW'(n_pmag_ff) << F) + NUMW'(n_amag_ff);
      numm     = (NUMW'(n_mmag_ff) << F) + NUMW'(n_amag_ff);
      hip      = nump >> W;
      him      = numm >> W;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_v_ff <= 1'b0;
      end else if (ben) begin
         p_v_ff <= n_v_ff;
      end
      if (ben) begin
         p_cls_ff  <= n_cls_ff;
         p_den_ff  <= p_den_in;
         p_negp_ff <= (n_pneg_ff != n_aneg_ff);
         p_negm_ff <= (n_mneg_ff != n_aneg_ff);
         p_ovfp_ff <= (hip >= NUMW'(p_den_in));
         p_ovfm_ff <= (him >= NUMW'(p_den_in));
         p_remp_ff <= hip[DVRW-1:0];
         p_remm_ff <= him[DVRW-1:0];
         p_lop_ff  <= nump[W-1:0];
         p_lom_ff  <= numm[W-1:0];
      end
   end

   for (genvar j = 0; j < W; j++) begin : g_div
      logic                    v_i, negp_i, negm_i, ovfp_i, ovfm_i;
      qrs_pkg::qrs_status_type cls_i;
      logic [DENW-1:0]         den_i;
      logic [DVRW-1:0]         remp_i, remm_i, shp, shm, remp_in, remm_in;
      logic [W-1:0]            lop_i, lom_i, qp_i, qm_i;
      logic                    gep, gem;

      if (j == 0) begin : g_head
         assign v_i    = p_v_ff;
         assign cls_i  = p_cls_ff;
         assign negp_i = p_negp_ff;
         assign negm_i = p_negm_ff;
         assign ovfp_i = p_ovfp_ff;
         assign ovfm_i = p_ovfm_ff;
         assign den_i  = p_den_ff;
         assign remp_i = p_remp_ff;
         assign remm_i = p_remm_ff;
         assign lop_i  = p_lop_ff;
         assign lom_i  = p_lom_ff;
         assign qp_i   = '0;
         assign qm_i   = '0;
      end else begin : g_link
         assign v_i    = dv_v_ff[j-1];
         assign cls_i  = dv_cls_ff[j-1];
         assign negp_i = dv_negp_ff[j-1];
         assign negm_i = dv_negm_ff[j-1];
         assign ovfp_i = dv_ovfp_ff[j-1];
         assign ovfm_i = dv_ovfm_ff[j-1];
         assign den_i  = dv_den_ff[j-1];
         assign remp_i = dv_remp_ff[j-1];
         assign remm_i = dv_remm_ff[j-1];
         assign lop_i  = dv_lop_ff[j-1];
         assign lom_i  = dv_lom_ff[j-1];
         assign qp_i   = dv_qp_ff[j-1];
         assign qm_i   = dv_qm_ff[j-1];
      end

      always_comb begin
         shp     = {remp_i[DVRW-2:0], lop_i[W-1]};
         shm     = {remm_i[DVRW-2:0], lom_i[W-1]};
         gep     = (shp >= DVRW'(den_i));
         gem     = (shm >= DVRW'(den_i));
         remp_in = gep ? shp - DVRW'(den_i) : shp;
         remm_in = gem ? shm - DVRW'(den_i) : shm;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_v_ff[j] <= 1'b0;
         end else if (ben) begin
            dv_v_ff[j] <= v_i;
         end
         if (ben) begin
            dv_cls_ff[j]  <= cls_i;
            dv_negp_ff[j] <= negp_i;
            dv_negm_ff[j] <= negm_i;
            dv_ovfp_ff[j] <= ovfp_i;
            dv_ovfm_ff[j] <= ovfm_i;
            dv_den_ff[j]  <= den_i;
            dv_remp_ff[j] <= remp_in;
            dv_remm_ff[j] <= remm_in;
            dv_lop_ff[j]  <= {lop_i[W-2:0], 1'b0};
            dv_lom_ff[j]  <= {lom_i[W-2:0], 1'b0};
            dv_qp_ff[j]   <= {qp_i[W-2:0], gep};
            dv_qm_ff[j]   <= {qm_i[W-2:0], gem};
         end
      end
   end

   always_comb begin
      cl_p = clamp_root(dv_negp_ff[W-1], dv_ovfp_ff[W-1], dv_qp_ff[W-1]);
      cl_m = clamp_root(dv_negm_ff[W-1], dv_ovfm_ff[W-1], dv_qm_ff[W-1]);
      if (dv_cls_ff[W-1] != qrs_pkg::ST_OK) begin
         rsp_status_in = dv_cls_ff[W-1];
      end else if (cl_p[W] || cl_m[W]) begin
         rsp_status_in = qrs_pkg::ST_SAT;
      end else begin
         rsp_status_in = qrs_pkg::ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ben) begin
         rsp_valid_ff <= dv_v_ff[W-1];
      end
      if (ben) begin
         rsp_status_ff <= rsp_status_in;
         rsp_plus_ff   <= (dv_cls_ff[W-1] == qrs_pkg::ST_OK) ? cl_p[W-1:0] : '0;
         rsp_minus_ff  <= (dv_cls_ff[W-1] == qrs_pkg::ST_OK) ? cl_m[W-1:0] : '0;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_plus  = rsp_plus_ff;
   assign rsp_root_minus = rsp_minus_ff;
   assign rsp_status     = rsp_status_ff;

   a_special_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == qrs_pkg::ST_A_ZERO
                        || rsp_status_ff == qrs_pkg::ST_D_NEG))
      |-> (rsp_plus_ff == '0 && rsp_minus_ff == '0))
      else $error("nonzero root on a special-case transaction");

   a_sat_clamped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff == qrs_pkg::ST_SAT)
      |-> (rsp_plus_ff == {1'b0, {(W-1){1'b1}}} || rsp_plus_ff == {1'b1, {(W-1){1'b0}}}
           || rsp_minus_ff == {1'b0, {(W-1){1'b1}}}
           || rsp_minus_ff == {1'b1, {(W-1){1'b0}}}))
      else $error("saturation flagged without a clamped root");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      pop |=> sq_v_ff[0])
      else $error("queue head popped but not taken by the root pipeline");

endmodule

`default_nettype wire

>>> src/quadratic_root_solver.sv
// Top level of the quadratic root solver: front end, job queue, back end.
// Depends on qrs_pkg, qrs_front, qrs_fifo and qrs_back.
//
//   channel  ports                                                 direction  content
//   req      req_valid req_stall req_coef_a/b/c                    in         Q16.16 a, b, c
//   rsp      rsp_valid rsp_stall rsp_root_plus/minus rsp_status    out        roots, status
//
// One transaction per cycle sustained while rsp_stall stays low. The square root and
// divider are pipelined, one result bit per stage.
// Reset is synchronous and clears all valid state; no clearing pass.
// rsp_stall freezes the back end; the front end and queue keep taking
// transactions until the queue (4 entries) fills, then req_stall rises.
`default_nettype none

module quadratic_root_solver (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_a,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_b,
   input  wire logic signed [qrs_pkg::WORD_BITS-1:0] req_coef_c,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic signed [qrs_pkg::WORD_BITS-1:0]      rsp_root_plus,
   output logic signed [qrs_pkg::WORD_BITS-1:0]      rsp_root_minus,
   output logic [1:0]                                rsp_status
);

   logic                 push, pop, fifo_empty, fifo_full;
   qrs_pkg::qrs_job_type push_job, head_job;

   qrs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_coef_a (req_coef_a),
      .req_coef_b (req_coef_b),
      .req_coef_c (req_coef_c),
      .fifo_full  (fifo_full),
      .push       (push),
      .push_job   (push_job)
   );

   qrs_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .empty    (fifo_empty),
      .full     (fifo_full)
   );

   qrs_back u_back (
      .clock          (clock),
      .reset          (reset),
      .fifo_empty     (fifo_empty),
      .head_job       (head_job),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_root_plus  (rsp_root_plus),
      .rsp_root_minus (rsp_root_minus),
      .rsp_status     (rsp_status)
   );

endmodule

`default_nettype wire

>>> dv/tb_quadratic_root_solver.sv
// Testbench for quadratic_root_solver: directed and random coefficient sets,
// roots predicted with wide integer arithmetic and compared per transaction.
// Depends on qrs_pkg and the solver RTL.
`timescale 1ns / 1ps

module tb_quadratic_root_solver;

   localparam int W = qrs_pkg::WORD_BITS;
   localparam int F = qrs_pkg::FRAC_BITS;

   typedef struct {
      logic signed [W-1:0] a, b, c;
   } coef_set_type;

   typedef struct {
      logic signed [W-1:0]     rp, rm;
      qrs_pkg::qrs_status_type st;
   } roots_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, rsp_stall = 0;
   logic req_stall, rsp_valid;
   logic signed [W-1:0] req_coef_a = 0, req_coef_b = 0, req_coef_c = 0;
   logic signed [W-1:0] rsp_root_plus, rsp_root_minus;
   logic [1:0] rsp_status;

   coef_set_type pending_sets[$];
   roots_type    expected_roots[$];
   int           errors = 0, n_sent = 0, n_checked = 0;
   int           send_idle_pct = 0, stall_pct = 0;
   bit           hold_send = 0;
   int           status_seen[4] = '{0, 0, 0, 0};

   quadratic_root_solver DUT (.*);

   initial begin
      forever #4 clock = ~clock;
   end

   // floor square root of a nonnegative value
   function automatic logic [131:0] isqrt(logic [131:0] d);
      logic [131:0] r, bitv;
      r = 0;
      for (int i = 65; i >= 0; i--) begin
         bitv = r | (132'd1 << i);
         if (bitv * bitv <= d) r = bitv;
      end
      return r;
   endfunction

   // num / (2|a|) rounded half away, with sign, saturated
   function automatic logic signed [W-1:0] root_of(logic signed [131:0] num,
         logic a_neg, logic [131:0] ma, ref bit sat);
      logic [131:0] mag, q;
      logic neg;
      mag = num < 0 ? -num : num;
      q = ((mag << F) + ma) / (ma * 2);
      neg = ((num < 0) != a_neg) && q != 0;
      if (!neg && q >= (132'd1 << (W - 1))) begin
         sat = 1;
         return {1'b0, {(W-1){1'b1}}};
      end
      if (neg && q > (132'd1 << (W - 1))) begin
         sat = 1;
         return {1'b1, {(W-1){1'b0}}};
      end
      return neg ? -q[W-1:0] : q[W-1:0];
   endfunction

   function automatic roots_type solve_quadratic(coef_set_type s);
      roots_type r;
      logic signed [131:0] a, b, c, d, sq;
      bit sat;
      sat = 0;
      r.rp = 0;
      r.rm = 0;
      a = s.a;
      b = s.b;
      c = s.c;
      if (a == 0) begin
         r.st = qrs_pkg::ST_A_ZERO;
         return r;
      end
      d = b * b - 4 * a * c;
      if (d < 0) begin
         r.st = qrs_pkg::ST_D_NEG;
         return r;
      end
      sq = isqrt(d);
      r.rp = root_of(-b + sq, a < 0, a < 0 ? -a : a, sat);
      r.rm = root_of(-b - sq, a < 0, a < 0 ? -a : a, sat);
      r.st = sat ? qrs_pkg::ST_SAT : qrs_pkg::ST_OK;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) n_sent++;
         if (pending_sets.size() > 0 && !hold_send &&
               $urandom_range(99) >= send_idle_pct) begin
            coef_set_type s;
            s = pending_sets.pop_front();
            expected_roots.push_back(solve_quadratic(s));
            req_valid <= 1;
            req_coef_a <= s.a;
            req_coef_b <= s.b;
            req_coef_c <= s.c;
         end else begin
            req_valid <= 0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            roots_type e;
            if (expected_roots.size() == 0) begin
               $error("unexpected transaction");
               errors++;
            end else begin
               e = expected_roots.pop_front();
               n_checked++;
               status_seen[e.st]++;
               if (rsp_root_plus !== e.rp) begin
                  $error("root_plus exp %0d got %0d", e.rp, rsp_root_plus);
                  errors++;
               end
               if (rsp_root_minus !== e.rm) begin
                  $error("root_minus exp %0d got %0d", e.rm, rsp_root_minus);
                  errors++;
               end
               if (rsp_status !== e.st) begin
                  $error("status exp %0d got %0d", e.st, rsp_status);
                  errors++;
               end
            end
         end
         rsp_stall <= $urandom_range(99) < stall_pct;
      end
   end

   function automatic logic signed [W-1:0] rand_coef();
      case ($urandom_range(5))
         0: return $urandom;
         1: return $signed($urandom_range(2000)) - 1000;
         2: return $signed($urandom_range(8 << 16)) - (4 << 16);
         3: return $urandom_range(1) ? {1'b0, {(W-1){1'b1}}} : {1'b1, {(W-1){1'b0}}};
         4: return $signed($urandom) >>> $urandom_range(31);
         default: return 0;
      endcase
   endfunction

   task automatic add_set(logic signed [W-1:0] a, b, c);
      coef_set_type s;
      s.a = a;
      s.b = b;
      s.c = c;
      pending_sets.push_back(s);
   endtask

   task automatic run_phase(int idle, int stall, int count);
      send_idle_pct = idle;
      stall_pct = stall;
      repeat (count) add_set(rand_coef(), rand_coef(), rand_coef());
      wait (pending_sets.size() == 0);
   endtask

   localparam logic signed [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE = 1 << F;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 0;
      add_set(0, ONE, ONE);
      add_set(0, 0, 0);
      add_set(ONE, 0, ONE);
      add_set(ONE, -3 * ONE, 2 * ONE);
      add_set(-ONE, 3 * ONE, -2 * ONE);
      add_set(ONE, 2 * ONE, ONE);
      add_set(ONE, 0, 0);
      add_set(1, MAXV, 0);
      add_set(-1, MINV, 0);
      add_set(MAXV, MAXV, MAXV);
      add_set(MINV, MINV, MINV);
      add_set(MINV, MAXV, MAXV);
      add_set(MAXV, MINV, MINV);
      add_set(1, 1, MINV);
      add_set(ONE, ONE, 0);
      add_set(-ONE, -ONE, 0);
      add_set(3, 1, 0);
      add_set(MAXV, 0, MINV);
      add_set(-1, 0, MAXV);
      wait (pending_sets.size() == 0);
      run_phase(0, 0, 400);
      run_phase(51, 0, 350);
      hold_send = 1;
      wait (expected_roots.size() == 0);
      hold_send = 0;
      run_phase(0, 51, 350);
      run_phase(7, 7, 350);
      run_phase(0, 0, 250);
      @(posedge clock);
      wait (!req_valid && expected_roots.size() == 0);
      stall_pct = 0;
      repeat (2 * W + 20) @(posedge clock);
      $display("Checked %0d solutions: ok %0d, a zero %0d, negative disc %0d, sat %0d",
         n_checked, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Simulation FAILED");
      $finish;
   end

endmodule

>>> sim.f
src/qrs_pkg.sv
src/qrs_front.sv
src/qrs_fifo.sv
src/qrs_back.sv
src/quadratic_root_solver.sv
dv/tb_quadratic_root_solver.sv
